[hdl/bdpc_pkg.sv]
// ----------------------------------------------------------------------------
// bdpc_pkg
// Shared types and constants of the button debounce and press classifier.
// ----------------------------------------------------------------------------
package bdpc_pkg;

    localparam int NUM_BUTTONS_DEF = 5;
    localparam int FIELD_W         = 5;
    localparam int TIME_W          = 32;
    localparam int CFG_W           = 16;
    localparam int CFG_IDX_W       = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE  = 2'd0,
        CFG_LONG_TIME = 2'd1,
        CFG_SHORT_EN  = 2'd2,
        CFG_LONG_EN   = 2'd3
    } t_cfg_reg;

    localparam logic [CFG_W-1:0]   DEBOUNCE_RST  = 16'd20;
    localparam logic [CFG_W-1:0]   LONG_TIME_RST = 16'd1000;
    localparam logic [FIELD_W-1:0] SHORT_EN_RST  = 5'd31;
    localparam logic [FIELD_W-1:0] LONG_EN_RST   = 5'd31;

    // per-button findings of one tick
    typedef struct packed {
        logic lvl;
        logic press_ev;
        logic rel_ev;
        logic short_ev;
        logic long_ev;
    } t_lane_res;

    // shared timing settings seen by every lane
    typedef struct packed {
        logic [CFG_W-1:0] debounce;
        logic [CFG_W-1:0] long_time;
    } t_lane_cfg;

endpackage

[hdl/bdpc_if.sv]
// ----------------------------------------------------------------------------
// bdpc channel interfaces
// Sample input, event output and register write channels.
// ----------------------------------------------------------------------------
interface bdpc_in_if import bdpc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] raw_levels;
    logic [TIME_W-1:0]  now_ms;

    modport source (output valid, output raw_levels, output now_ms, input ready);
    modport sink   (input valid, input raw_levels, input now_ms, output ready);
endinterface

interface bdpc_out_if import bdpc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] stable_levels;
    logic [FIELD_W-1:0] press_events;
    logic [FIELD_W-1:0] release_events;
    logic [FIELD_W-1:0] short_events;
    logic [FIELD_W-1:0] long_events;

    modport source (output valid, output stable_levels, output press_events,
                    output release_events, output short_events, output long_events,
                    input ready);
    modport sink   (input valid, input stable_levels, input press_events,
                    input release_events, input short_events, input long_events,
                    output ready);
endinterface

interface bdpc_cfg_if import bdpc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, output reg_index, output data, input ready);
    modport sink   (input valid, input reg_index, input data, output ready);
endinterface

[hdl/bdpc_lane.sv]
// ----------------------------------------------------------------------------
// bdpc_lane
// State and classification logic of one button.
// ----------------------------------------------------------------------------
module bdpc_lane import bdpc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic              i_raw,
    input  logic [TIME_W-1:0] i_now,
    input  t_lane_cfg         i_cfg,
    input  logic              i_short_en,
    input  logic              i_long_en,
    output t_lane_res         o_res
);

    logic              r_started;
    logic              r_stable;
    logic              r_last_raw;
    logic [TIME_W-1:0] r_change_time;
    logic [TIME_W-1:0] r_press_time;
    logic              r_long_done;

    logic              n_stable;
    logic              n_last_raw;
    logic [TIME_W-1:0] n_change_time;
    logic [TIME_W-1:0] n_press_time;
    logic              n_long_done;

    logic w_changed;
    logic w_settled;
    logic w_flip;
    logic w_press;
    logic w_rel;
    logic w_long_ready;
    logic w_long;
    logic w_ld_eff;

    always_comb begin
        w_changed = i_raw != r_last_raw;
        // a fresh change restarts the window, so only a zero debounce passes
        w_settled = w_changed ? (i_cfg.debounce == '0)
                              : ((i_now - r_change_time) >= TIME_W'(i_cfg.debounce));
        w_flip    = w_settled && (r_stable != i_raw);
        w_press   = w_flip && i_raw;
        w_rel     = w_flip && !i_raw;
        w_ld_eff  = w_press ? 1'b0 : r_long_done;
        w_long_ready = w_press ? (i_cfg.long_time == '0)
                               : ((i_now - r_press_time) >= TIME_W'(i_cfg.long_time));
        n_stable  = w_flip ? i_raw : r_stable;
        w_long    = i_long_en && n_stable && !w_ld_eff && w_long_ready;

        if (r_started) begin
            n_last_raw    = i_raw;
            n_change_time = w_changed ? i_now : r_change_time;
            n_press_time  = w_press ? i_now : r_press_time;
            n_long_done   = w_ld_eff || w_long;
            o_res.lvl      = n_stable;
            o_res.press_ev = w_press;
            o_res.rel_ev   = w_rel;
            o_res.short_ev = w_rel && i_short_en && !r_long_done;
            o_res.long_ev  = w_long;
        end else begin
            // first tick: adopt the raw level without events
            n_last_raw    = i_raw;
            n_change_time = i_now;
            n_press_time  = r_press_time;
            n_long_done   = r_long_done;
            n_stable      = i_raw;
            o_res.lvl      = i_raw;
            o_res.press_ev = 1'b0;
            o_res.rel_ev   = 1'b0;
            o_res.short_ev = 1'b0;
            o_res.long_ev  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started     <= 1'b0;
            r_stable      <= 1'b0;
            r_last_raw    <= 1'b0;
            r_change_time <= '0;
            r_press_time  <= '0;
            r_long_done   <= 1'b0;
        end else if (i_take) begin
            r_started     <= 1'b1;
            r_stable      <= n_stable;
            r_last_raw    <= n_last_raw;
            r_change_time <= n_change_time;
            r_press_time  <= n_press_time;
            r_long_done   <= n_long_done;
        end
    end

endmodule

[hdl/bdpc_merge.sv]
// ----------------------------------------------------------------------------
// bdpc_merge
// Gathers the lane findings into the registered result of one tick.
// ----------------------------------------------------------------------------
module bdpc_merge import bdpc_pkg::*; #(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_take,
    input  t_lane_res    i_res [NUM_BUTTONS],
    output logic         o_can_take,
    bdpc_out_if.source   o_out
);

    logic               r_valid;
    logic [FIELD_W-1:0] r_lvl;
    logic [FIELD_W-1:0] r_press;
    logic [FIELD_W-1:0] r_rel;
    logic [FIELD_W-1:0] r_short;
    logic [FIELD_W-1:0] r_long;

    logic [FIELD_W-1:0] w_lvl;
    logic [FIELD_W-1:0] w_press;
    logic [FIELD_W-1:0] w_rel;
    logic [FIELD_W-1:0] w_short;
    logic [FIELD_W-1:0] w_long;

    // buttons past the field width are dropped, missing ones read as zero
    for (genvar b = 0; b < FIELD_W; b++) begin : g_bit
        if (b < NUM_BUTTONS) begin : g_on
            assign w_lvl[b]   = i_res[b].lvl;
            assign w_press[b] = i_res[b].press_ev;
            assign w_rel[b]   = i_res[b].rel_ev;
            assign w_short[b] = i_res[b].short_ev;
            assign w_long[b]  = i_res[b].long_ev;
        end else begin : g_off
            assign w_lvl[b]   = 1'b0;
            assign w_press[b] = 1'b0;
            assign w_rel[b]   = 1'b0;
            assign w_short[b] = 1'b0;
            assign w_long[b]  = 1'b0;
        end
    end

    assign o_can_take = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_take) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_lvl   <= w_lvl;
            r_press <= w_press;
            r_rel   <= w_rel;
            r_short <= w_short;
            r_long  <= w_long;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.stable_levels  = r_lvl;
    assign o_out.press_events   = r_press;
    assign o_out.release_events = r_rel;
    assign o_out.short_events   = r_short;
    assign o_out.long_events    = r_long;

endmodule

[hdl/button_debounce_press_classifier_unit.sv]
// a sample transfer shows its result at the output register in the next cycle
// one sample per cycle unless output stalls; each lane updates in the transfer cycle
// the output register frees in the cycle its result transfers, so input stays open
// reset: synchronous, active low; clears button state and restores register defaults
// ----------------------------------------------------------------------------
// button_debounce_press_classifier_unit
// Debounces a row of buttons and reports press, release, short and long events.
// ----------------------------------------------------------------------------
module button_debounce_press_classifier_unit import bdpc_pkg::*; #(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bdpc_in_if.sink     i_in,
    bdpc_out_if.source  o_out,
    bdpc_cfg_if.sink    i_cfg
);

    logic [CFG_W-1:0]   r_debounce;
    logic [CFG_W-1:0]   r_long_time;
    logic [FIELD_W-1:0] r_short_en;
    logic [FIELD_W-1:0] r_long_en;

    logic      w_can_take;
    logic      w_take;
    t_lane_cfg w_lane_cfg;
    t_lane_res w_res [NUM_BUTTONS];

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce  <= DEBOUNCE_RST;
            r_long_time <= LONG_TIME_RST;
            r_short_en  <= SHORT_EN_RST;
            r_long_en   <= LONG_EN_RST;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_reg'(i_cfg.reg_index))
                CFG_DEBOUNCE:  r_debounce  <= i_cfg.data;
                CFG_LONG_TIME: r_long_time <= i_cfg.data;
                CFG_SHORT_EN:  r_short_en  <= i_cfg.data[FIELD_W-1:0];
                CFG_LONG_EN:   r_long_en   <= i_cfg.data[FIELD_W-1:0];
                default:       r_debounce  <= r_debounce;
            endcase
        end
    end

    assign w_lane_cfg.debounce  = r_debounce;
    assign w_lane_cfg.long_time = r_long_time;

    assign i_in.ready = w_can_take;
    assign w_take     = i_in.valid && w_can_take;

    for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
        logic w_raw;
        logic w_sen;
        logic w_len;

        // buttons past the field width see a released level and no enables
        if (g < FIELD_W) begin : g_wired
            assign w_raw = i_in.raw_levels[g];
            assign w_sen = r_short_en[g];
            assign w_len = r_long_en[g];
        end else begin : g_idle
            assign w_raw = 1'b0;
            assign w_sen = 1'b0;
            assign w_len = 1'b0;
        end

        bdpc_lane u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_take     (w_take),
            .i_raw      (w_raw),
            .i_now      (i_in.now_ms),
            .i_cfg      (w_lane_cfg),
            .i_short_en (w_sen),
            .i_long_en  (w_len),
            .o_res      (w_res[g])
        );
    end

    bdpc_merge #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (w_take),
        .i_res      (w_res),
        .o_can_take (w_can_take),
        .o_out      (o_out)
    );

    // a sample transfer always produces a result in the next cycle
    a_take_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> o_out.valid)
        else $error("accepted sample produced no result");

    a_press_rel_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ((o_out.press_events & o_out.release_events) == '0))
        else $error("press and release on the same button");

    a_short_needs_rel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ((o_out.short_events & ~o_out.release_events) == '0))
        else $error("short event without release");

    a_level_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (((o_out.press_events | o_out.long_events)
                          & ~o_out.stable_levels) == '0
                         && (o_out.release_events & o_out.stable_levels) == '0))
        else $error("event disagrees with stable level");

endmodule

[test/button_debounce_press_classifier_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// button_debounce_press_classifier_unit_tb
// Drives sampling ticks through the debouncer at random rates, tracks the
// per-button debounce and press timing state in its own predictor, and checks
// every result field by field. Register settings change between phases.
// ----------------------------------------------------------------------------
module button_debounce_press_classifier_unit_tb;
    import bdpc_pkg::*;

    localparam int NUM_BTN      = NUM_BUTTONS_DEF;
    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_AT      = 450;
    localparam int HOLD_CYCLES  = 120;
    localparam int OPENING_LEN  = 20;

    typedef struct packed {
        logic [FIELD_W-1:0] stable_levels;
        logic [FIELD_W-1:0] press_events;
        logic [FIELD_W-1:0] release_events;
        logic [FIELD_W-1:0] short_events;
        logic [FIELD_W-1:0] long_events;
    } t_tick_result;

    class tick_scoreboard;
        logic [CFG_W-1:0]   debounce_ms;
        logic [CFG_W-1:0]   long_ms;
        logic [FIELD_W-1:0] short_en;
        logic [FIELD_W-1:0] long_en;
        logic [NUM_BTN-1:0] started;
        logic [NUM_BTN-1:0] stable;
        logic [NUM_BTN-1:0] last_raw;
        logic [NUM_BTN-1:0] long_done;
        logic [TIME_W-1:0]  change_at [NUM_BTN];
        logic [TIME_W-1:0]  press_at [NUM_BTN];
        t_tick_result       expected_ticks [$];
        int                 errors;
        int                 results_seen;
        int                 presses;
        int                 shorts;
        int                 longs;

        function new();
            debounce_ms  = DEBOUNCE_RST;
            long_ms      = LONG_TIME_RST;
            short_en     = SHORT_EN_RST;
            long_en      = LONG_EN_RST;
            started      = '0;
            stable       = '0;
            last_raw     = '0;
            long_done    = '0;
            errors       = 0;
            results_seen = 0;
            presses      = 0;
            shorts       = 0;
            longs        = 0;
            for (int b = 0; b < NUM_BTN; b++) begin
                change_at[b] = '0;
                press_at[b]  = '0;
            end
        endfunction

        task report(input string what);
            errors++;
            if (errors <= 100) begin
                $display("[%0t] MISMATCH: %s", $realtime, what);
            end
        endtask

        function void set_register(input t_cfg_reg idx, input logic [CFG_W-1:0] val);
            case (idx)
                CFG_DEBOUNCE:  debounce_ms = val;
                CFG_LONG_TIME: long_ms     = val;
                CFG_SHORT_EN:  short_en    = val[FIELD_W-1:0];
                CFG_LONG_EN:   long_en     = val[FIELD_W-1:0];
                default: ;
            endcase
        endfunction

        // one sampling tick through every button lane
        function void note_sample(input logic [FIELD_W-1:0] raw, input logic [TIME_W-1:0] now);
            t_tick_result res;
            logic [TIME_W-1:0] elapsed;
            res = '0;
            for (int b = 0; b < NUM_BTN; b++) begin
                if (!started[b]) begin
                    // first tick: raw level taken as stable, no events
                    started[b]   = 1'b1;
                    stable[b]    = raw[b];
                    last_raw[b]  = raw[b];
                    change_at[b] = now;
                end else begin
                    if (raw[b] != last_raw[b]) begin
                        last_raw[b]  = raw[b];
                        change_at[b] = now;
                    end
                    elapsed = now - change_at[b];
                    if (elapsed >= TIME_W'(debounce_ms) && stable[b] != raw[b]) begin
                        stable[b] = raw[b];
                        if (raw[b]) begin
                            res.press_events[b] = 1'b1;
                            press_at[b]  = now;
                            long_done[b] = 1'b0;
                        end else begin
                            res.release_events[b] = 1'b1;
                            if (short_en[b] && !long_done[b]) begin
                                res.short_events[b] = 1'b1;
                            end
                        end
                    end
                    elapsed = now - press_at[b];
                    if (long_en[b] && stable[b] && !long_done[b] &&
                        elapsed >= TIME_W'(long_ms)) begin
                        long_done[b] = 1'b1;
                        res.long_events[b] = 1'b1;
                    end
                end
                res.stable_levels[b] = stable[b];
            end
            expected_ticks.push_back(res);
        endfunction

        task compare_field(input string name, input logic [FIELD_W-1:0] got,
                           input logic [FIELD_W-1:0] want);
            if (got !== want) begin
                report($sformatf("result %0d %s got %b expected %b",
                                 results_seen, name, got, want));
            end
        endtask

        task check_result(input t_tick_result got);
            t_tick_result want;
            if (expected_ticks.size() == 0) begin
                report($sformatf("result %0d arrived with nothing outstanding", results_seen));
            end else begin
                want = expected_ticks.pop_front();
                compare_field("stable_levels", got.stable_levels, want.stable_levels);
                compare_field("press_events", got.press_events, want.press_events);
                compare_field("release_events", got.release_events, want.release_events);
                compare_field("short_events", got.short_events, want.short_events);
                compare_field("long_events", got.long_events, want.long_events);
                presses += $countones(want.press_events);
                shorts  += $countones(want.short_events);
                longs   += $countones(want.long_events);
            end
            results_seen++;
        endtask

        task flush_leftovers();
            while (expected_ticks.size() != 0) begin
                void'(expected_ticks.pop_front());
                report("expected result never arrived");
            end
        endtask

        function int pending();
            return expected_ticks.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    bdpc_in_if  in_ch ();
    bdpc_out_if out_ch ();
    bdpc_cfg_if cfg_ch ();

    button_debounce_press_classifier_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always #4 i_clk = ~i_clk;

    tick_scoreboard sb;

    int              tx_run  = 0;
    bit              tx_calm = 1'b0;
    logic [TIME_W-1:0] clock_ms = '0;
    int              settings_used = 0;

    // bounce checks, exact debounce edge, long press from first tick, time wrap
    logic [FIELD_W-1:0] opening_raw [OPENING_LEN] = '{
        5'b10101, 5'b10101, 5'b11111, 5'b11101, 5'b11111,
        5'b11111, 5'b11111, 5'b00000, 5'b00000, 5'b11111,
        5'b11111, 5'b11111, 5'b11111, 5'b00110, 5'b00110,
        5'b00000, 5'b11111, 5'b11111, 5'b11111, 5'b00000
    };
    logic [TIME_W-1:0] opening_ms [OPENING_LEN] = '{
        32'd5,    32'd1005, 32'd1010, 32'd1020, 32'd1029,
        32'd1030, 32'd1049, 32'd1100, 32'd1120, 32'hFFFF_FFF0,
        32'd4,    32'd1003, 32'd1004, 32'd1008, 32'd1280,
        32'd1296, 32'd1312, 32'd1332, 32'hFFFF_FFFF, 32'd0
    };

    // each stretch is picked at random as busy with no gaps or as random gaps
    function automatic int draw_gap(ref int run_left, ref bit calm);
        if (run_left == 0) begin
            run_left = $urandom_range(8, 40);
            calm     = ($urandom_range(0, 2) == 0);
        end
        run_left--;
        return calm ? 0 : $urandom_range(0, 6);
    endfunction

    task automatic send_sample(input logic [FIELD_W-1:0] raw, input logic [TIME_W-1:0] now);
        int gap;
        gap = draw_gap(tx_run, tx_calm);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.raw_levels <= raw;
        in_ch.now_ms     <= now;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        sb.note_sample(raw, now);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_W-1:0] val);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.data      <= val;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        sb.set_register(idx, val);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // mostly held patterns with short bursts of bounce, a little pure noise
    task automatic run_phase(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] lng,
                             input logic [FIELD_W-1:0] smask, input logic [FIELD_W-1:0] lmask,
                             input int count, input int step_max, input int hold_odds);
        logic [FIELD_W-1:0] target;
        logic [FIELD_W-1:0] raw;
        int settle;
        wait_drained();
        write_reg(CFG_DEBOUNCE, deb);
        write_reg(CFG_LONG_TIME, lng);
        write_reg(CFG_SHORT_EN, {11'($urandom), smask});
        write_reg(CFG_LONG_EN, {11'($urandom), lmask});
        settings_used++;
        target = 5'($urandom);
        settle = 0;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) < 2) begin
                clock_ms = $urandom();
            end else begin
                clock_ms = clock_ms + 32'($urandom_range(0, step_max));
            end
            if ($urandom_range(0, hold_odds) == 0) begin
                target = target ^ 5'($urandom_range(1, 31));
                settle = $urandom_range(0, 4);
            end
            raw = target;
            if (settle > 0) begin
                raw = target ^ 5'($urandom_range(0, 31));
                settle--;
            end
            if ($urandom_range(0, 29) == 0) begin
                raw = 5'($urandom_range(0, 31));
            end
            send_sample(raw, clock_ms);
        end
    endtask

    initial begin : stimulus
        sb = new();
        i_rst_n          <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.raw_levels <= '0;
        in_ch.now_ms     <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.reg_index <= CFG_DEBOUNCE;
        cfg_ch.data      <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < OPENING_LEN; k++) begin
            send_sample(opening_raw[k], opening_ms[k]);
        end
        clock_ms = 32'd2000;

        run_phase(DEBOUNCE_RST, LONG_TIME_RST, 5'd31, 5'd31, 300, 40, 40);
        run_phase(16'd0, 16'd0, 5'($urandom), 5'($urandom), 250, 8, 6);
        run_phase(16'hFFFF, 16'hFFFF, 5'd31, 5'd0, 250, 20000, 20);
        run_phase(16'($urandom_range(0, 60)), 16'($urandom_range(0, 1500)),
                  5'($urandom), 5'($urandom), 400, 50, 25);
        run_phase(16'd5, 16'd100, 5'd0, 5'd31, 300, 15, 15);
        clock_ms = 32'hFFFF_F000;
        run_phase(16'd30, 16'd600, 5'd31, 5'd31, 400, 40, 20);

        wait_drained();
        sb.flush_leftovers();
        $display("checked %0d ticks over %0d register settings plus the opening sequence",
                 sb.results_seen, settings_used);
        $display("events predicted: %0d presses, %0d short presses, %0d long presses",
                 sb.presses, sb.shorts, sb.longs);
        if (sb.errors == 0) begin
            $display("button_debounce_press_classifier_unit_tb: done, clean");
        end else begin
            $display("button_debounce_press_classifier_unit_tb: done, errors");
        end
        $finish;
    end

    initial begin : result_sink
        int gap;
        int rx_run;
        bit rx_calm;
        bit held;
        t_tick_result got;
        rx_run  = 0;
        rx_calm = 1'b0;
        held    = 1'b0;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            gap = draw_gap(rx_run, rx_calm);
            // one long stall so the output backs up into the sample channel
            if (!held && sb.results_seen == HOLD_AT) begin
                gap  = HOLD_CYCLES;
                held = 1'b1;
            end
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (out_ch.valid !== 1'b1);
            got.stable_levels  = out_ch.stable_levels;
            got.press_events   = out_ch.press_events;
            got.release_events = out_ch.release_events;
            got.short_events   = out_ch.short_events;
            got.long_events    = out_ch.long_events;
            sb.check_result(got);
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("button_debounce_press_classifier_unit_tb: done, errors");
        $finish;
    end

endmodule
